// ===== sv/utf8d_pkg.sv =====
package utf8d_pkg;

  // replacement character and scalar limits
  localparam logic [20:0] REPL_CHAR     = 21'h00FFFD;
  localparam logic [20:0] MAX_SCALAR    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO       = 21'h00D800;
  localparam logic [20:0] SURR_HI       = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO_BYTE  = 21'h000080;
  localparam logic [20:0] MIN_THREE     = 21'h000800;
  localparam logic [20:0] MIN_FOUR      = 21'h010000;

  // sequence length implied by a lead byte
  localparam logic [2:0] LEN_INVALID = 3'd0;
  localparam logic [2:0] LEN_ONE     = 3'd1;
  localparam logic [2:0] LEN_TWO     = 3'd2;
  localparam logic [2:0] LEN_THREE   = 3'd3;
  localparam logic [2:0] LEN_FOUR    = 3'd4;

  // continuation byte tag in the top two bits
  localparam logic [1:0] CONT_TAG = 2'b10;

  // one decoded multibyte sequence
  typedef struct packed {
    logic [20:0] value;
    logic        bad;
  } seq_result_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = LEN_ONE;
    end else if (b[7:5] == 3'b110) begin
      len = LEN_TWO;
    end else if (b[7:4] == 4'b1110) begin
      len = LEN_THREE;
    end else if (b[7:3] == 5'b11110) begin
      len = LEN_FOUR;
    end else begin
      len = LEN_INVALID;
    end
    return len;
  endfunction

  // assemble held bytes plus the final byte, flag overlong, surrogate, out of range
  function automatic seq_result_t decode_seq(input logic [7:0] b0, input logic [7:0] b1,
                                             input logic [7:0] b2, input logic [7:0] last,
                                             input logic [2:0] len);
    seq_result_t r;
    r.value = '0;
    r.bad   = 1'b1;
    unique case (len)
      LEN_TWO: begin
        r.value = {10'd0, b0[4:0], last[5:0]};
        r.bad   = (r.value < MIN_TWO_BYTE);
      end
      LEN_THREE: begin
        r.value = {5'd0, b0[3:0], b1[5:0], last[5:0]};
        r.bad   = (r.value < MIN_THREE) || ((r.value >= SURR_LO) && (r.value <= SURR_HI));
      end
      LEN_FOUR: begin
        r.value = {b0[2:0], b1[5:0], b2[5:0], last[5:0]};
        r.bad   = (r.value < MIN_FOUR) || (r.value > MAX_SCALAR);
      end
      default: begin
        r.value = REPL_CHAR;
        r.bad   = 1'b1;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== sv/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder
// Input channel (in_valid/in_ready): one text byte per word, with end_of_text
// set on the final byte of a text. Output channel (out_valid/out_ready): one
// Unicode code point per word, with replaced, item_last, text_done and
// text_all_valid flags. A byte yields zero to four output words; bytes that
// only extend an open sequence yield none.
// The byte is captured in an input register, decoded from there and loaded
// into the result register once that is free, which drives the first word
// of the byte. A byte is taken every cycle as long as each byte yields at
// most one word and the receiver keeps out_ready high; a byte that yields
// several words holds the result register until all of them are taken,
// which only happens on malformed input or when a text ends inside an open
// sequence.
// When the receiver stalls, the result register holds its word and the input
// register fills, after which in_ready drops until out_ready returns.
// Synchronous reset empties both registers, drops any open sequence and
// starts a fresh text; in_ready is low while rst is high.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] code_point,
  output logic        replaced,
  output logic        item_last,
  output logic        text_done,
  output logic        text_all_valid
);

  // input register
  logic       ib_valid;
  logic [7:0] ib_byte;
  logic       ib_eot;

  // open sequence state
  logic [7:0] pb0, pb1, pb2;
  logic [1:0] pcnt;
  logic       allv;

  // result register: remaining words, the final word, text flags
  logic [2:0]  ob_cnt;
  logic [20:0] ob_cp;
  logic        ob_rep;
  logic        ob_eot;
  logic        ob_av;

  // decode signals
  logic [2:0]  need;
  logic [2:0]  blen;
  logic        is_cont;
  logic        cont_ok;
  logic        store;
  logic        complete;
  logic        flush_bad;
  logic        do_start;
  logic [1:0]  flush_n;
  logic        has_val;
  logic [20:0] val_cp;
  logic        val_rep;
  logic [1:0]  hold_new;
  logic [2:0]  n_words;
  logic [20:0] last_cp;
  logic        last_rep;
  logic        any_rep;
  logic        av_out;
  logic        ob_free;
  logic        adv;
  logic        in_fire;
  logic        out_fire;
  utf8d_pkg::seq_result_t seq;

  // per-byte decode against the open sequence
  always_comb begin
    need      = utf8d_pkg::lead_len(pb0);
    blen      = utf8d_pkg::lead_len(ib_byte);
    is_cont   = (ib_byte[7:6] == utf8d_pkg::CONT_TAG);
    cont_ok   = (pcnt != 2'd0) && is_cont && (need >= utf8d_pkg::LEN_TWO);
    store     = cont_ok && (({1'b0, pcnt} + 3'd1) < need);
    complete  = cont_ok && !store;
    flush_bad = (pcnt != 2'd0) && !cont_ok;
    do_start  = (pcnt == 2'd0) || flush_bad;
    flush_n   = flush_bad ? pcnt : 2'd0;
    seq       = utf8d_pkg::decode_seq(pb0, pb1, pb2, ib_byte, need);

    has_val  = 1'b0;
    val_cp   = utf8d_pkg::REPL_CHAR;
    val_rep  = 1'b1;
    hold_new = 2'd0;
    if (complete) begin
      has_val = 1'b1;
      val_cp  = seq.bad ? utf8d_pkg::REPL_CHAR : seq.value;
      val_rep = seq.bad;
    end else if (store) begin
      hold_new = pcnt + 2'd1;
    end else if (do_start) begin
      if (blen == utf8d_pkg::LEN_ONE) begin
        has_val = 1'b1;
        val_cp  = {13'd0, ib_byte};
        val_rep = 1'b0;
      end else if (blen == utf8d_pkg::LEN_INVALID) begin
        has_val = 1'b1;
      end else begin
        hold_new = 2'd1;
      end
    end

    n_words  = {1'b0, flush_n} + {2'd0, has_val} + (ib_eot ? {1'b0, hold_new} : 3'd0);
    last_cp  = has_val ? val_cp : utf8d_pkg::REPL_CHAR;
    last_rep = has_val ? val_rep : 1'b1;
    any_rep  = (flush_n != 2'd0) || (has_val && val_rep) || (ib_eot && (hold_new != 2'd0));
    av_out   = allv && !any_rep;
  end

  // handshake
  assign out_valid = (ob_cnt != 3'd0);
  assign out_fire  = out_valid && out_ready;
  assign ob_free   = (ob_cnt == 3'd0) || (out_ready && (ob_cnt == 3'd1));
  assign adv       = ib_valid && ((n_words == 3'd0) || ob_free);
  assign in_ready  = !rst && (!ib_valid || adv);
  assign in_fire   = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_fire) begin
      ib_valid <= 1'b1;
    end else if (adv) begin
      ib_valid <= 1'b0;
    end
    if (in_fire) begin
      ib_byte <= text_byte;
      ib_eot  <= end_of_text;
    end
  end

  // open sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= 2'd0;
      allv <= 1'b1;
    end else if (adv) begin
      pcnt <= ib_eot ? 2'd0 : hold_new;
      allv <= ib_eot ? 1'b1 : av_out;
    end
    if (adv) begin
      if (store && (pcnt == 2'd1)) begin
        pb1 <= ib_byte;
      end
      if (store && (pcnt == 2'd2)) begin
        pb2 <= ib_byte;
      end
      if (do_start && !complete && !store && (blen >= utf8d_pkg::LEN_TWO)) begin
        pb0 <= ib_byte;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 3'd0;
    end else if (adv && (n_words != 3'd0)) begin
      ob_cnt <= n_words;
    end else if (out_fire) begin
      ob_cnt <= ob_cnt - 3'd1;
    end
    if (adv && (n_words != 3'd0)) begin
      ob_cp  <= last_cp;
      ob_rep <= last_rep;
      ob_eot <= ib_eot;
      ob_av  <= av_out;
    end
  end

  // leading words of a byte are replacements, the final one carries the flags
  assign item_last      = (ob_cnt == 3'd1);
  assign code_point     = item_last ? ob_cp : utf8d_pkg::REPL_CHAR;
  assign replaced       = item_last ? ob_rep : 1'b1;
  assign text_done      = item_last && ob_eot;
  assign text_all_valid = item_last && ob_eot && ob_av;

endmodule

// ===== sv/utf8d_checker.sv =====
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic        replaced,
  input logic        item_last,
  input logic        text_done,
  input logic        text_all_valid
);

  // a replaced word always carries the replacement character
  a_repl_char: assert property (@(posedge clk) disable iff (rst)
    (out_valid && replaced) |-> (code_point == utf8d_pkg::REPL_CHAR))
    else $error("replaced word without U+FFFD");

  // decoded words are scalar values, never surrogates
  a_scalar: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !replaced) |->
      ((code_point <= utf8d_pkg::MAX_SCALAR) &&
       ((code_point < utf8d_pkg::SURR_LO) || (code_point > utf8d_pkg::SURR_HI))))
    else $error("decoded value is not a scalar value");

  // text flags only on the final word of a byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (text_done || text_all_valid)) |-> (item_last && text_done))
    else $error("text flags off the final word");

  // a valid text cannot end on a replacement
  a_valid_text: assert property (@(posedge clk) disable iff (rst)
    (out_valid && text_all_valid) |-> !replaced)
    else $error("all-valid text ends in a replacement");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(code_point) && $stable(item_last)))
    else $error("stalled output word changed");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .code_point     (code_point),
  .replaced       (replaced),
  .item_last      (item_last),
  .text_done      (text_done),
  .text_all_valid (text_all_valid)
);
